[design/lfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types, codes and helpers for the LED frame packet receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

  // Protocol bytes
  localparam logic [7:0] START_BYTE = 8'h9C;
  localparam logic [7:0] TYPE_DATA  = 8'hDA;
  localparam logic [7:0] TYPE_CMD   = 8'hC0;
  localparam logic [7:0] TYPE_RESP  = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'h36;
  localparam logic [7:0] ACK_BYTE   = 8'hAC;

  // Result kinds
  localparam logic [2:0] KIND_PIXEL  = 3'd0;
  localparam logic [2:0] KIND_COMMIT = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_ACK    = 3'd3;
  localparam logic [2:0] KIND_DROP   = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_START = 3'd1;
  localparam logic [2:0] ERR_SHORT     = 3'd2;
  localparam logic [2:0] ERR_BAD_END   = 3'd3;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd4;
  localparam logic [2:0] ERR_BAD_SLICE = 3'd5;

  // Header byte positions
  localparam int          POS_W       = 17;
  localparam logic [16:0] POS_START   = 17'd0;
  localparam logic [16:0] POS_TYPE    = 17'd1;
  localparam logic [16:0] POS_LEN_HI  = 17'd2;
  localparam logic [16:0] POS_LEN_LO  = 17'd3;
  localparam logic [16:0] POS_INDEX   = 17'd4;
  localparam logic [16:0] POS_COUNT   = 17'd5;
  localparam logic [16:0] POS_PAYLOAD = 17'd6;

  // Configuration
  localparam int          APB_AW         = 2;
  localparam logic [1:0]  ADDR_MATRIX    = 2'd0;
  localparam logic [15:0] MATRIX_RESET   = 16'd256;

  // Slice base divider: one quotient bit per cycle
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_MUL = 3'b100
  } lfr_state_t;

  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic div_step;  // one restoring-division step
    logic mul_load;  // scale quotient by slice index and load base
  } lfr_cmd_t;

  typedef struct packed {
    logic need_div;  // accepted count byte of a valid data frame
    logic out_stall; // result register full and not being taken
  } lfr_stat_t;

  // Remainder modulo 3 of a 16-bit value by base-4 digit folding
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

endpackage

[design/lfr_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_in_if
// Packet byte channel: one byte and its last-byte mark per beat.
// ----------------------------------------------------------------------------
interface lfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

[design/lfr_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_out_if
// Result channel: one pixel write, commit, clear, ack or drop per beat.
// ----------------------------------------------------------------------------
interface lfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  ack_byte;
  logic [2:0]  error_code;

  modport source (output valid, result_kind, pixel_index, red, green, blue,
                  ack_byte, error_code, input ready);
  modport sink   (input valid, result_kind, pixel_index, red, green, blue,
                  ack_byte, error_code, output ready);
endinterface

[design/lfr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_ctrl
// Sequencer: byte acceptance, slice-base division and scaling steps.
// ----------------------------------------------------------------------------
module lfr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfr_pkg::lfr_stat_t stat,
  output lfr_pkg::lfr_cmd_t  cmd
);

  lfr_pkg::lfr_state_t                state_r, state_nxt;
  logic [lfr_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;

  localparam logic [lfr_pkg::DIV_CNT_W-1:0] CNT_LAST =
    lfr_pkg::DIV_CNT_W'(lfr_pkg::DIV_STEPS - 1);

  assign in_ready     = (state_r == lfr_pkg::ST_RUN) && !stat.out_stall;
  assign cmd.accept   = in_ready && in_valid;
  assign cmd.div_step = (state_r == lfr_pkg::ST_DIV);
  assign cmd.mul_load = (state_r == lfr_pkg::ST_MUL);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      lfr_pkg::ST_RUN: begin
        if (cmd.accept && stat.need_div) begin
          state_nxt = lfr_pkg::ST_DIV;
          cnt_nxt   = '0;
        end
      end
      lfr_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = lfr_pkg::ST_MUL;
        end
      end
      lfr_pkg::ST_MUL: begin
        state_nxt = lfr_pkg::ST_RUN;
      end
      default: begin
        state_nxt = lfr_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfr_pkg::ST_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfr_pkg::ST_DIV && cnt_r == CNT_LAST) |=> state_r == lfr_pkg::ST_MUL)
    else $error("divider did not hand over to scaling after its last step");

  a_mul_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lfr_pkg::ST_MUL |=> state_r == lfr_pkg::ST_RUN)
    else $error("scaling step did not return to byte acceptance");

  a_div_go: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.need_div) |=> (state_r == lfr_pkg::ST_DIV && cnt_r == '0))
    else $error("count byte of a data frame did not start the divider");

endmodule

[design/lfr_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_dpath
// Packet parse registers, slice-base divider and multiplier, result register.
// ----------------------------------------------------------------------------
module lfr_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  lfr_pkg::lfr_cmd_t  cmd,
  output lfr_pkg::lfr_stat_t stat,
  input  logic [7:0]         in_data,
  input  logic               in_last,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic [15:0]        matrix_pixels,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [2:0]         out_kind,
  output logic [15:0]        out_index,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_ack,
  output logic [2:0]         out_err
);

  // Packet state
  logic [16:0] pos_r,    pos_nxt;
  logic [7:0]  ftype_r,  ftype_nxt;
  logic [15:0] flen_r,   flen_nxt;
  logic [15:0] limit_r,  limit_nxt;
  logic [7:0]  snum_r,   snum_nxt;
  logic [7:0]  stot_r,   stot_nxt;
  logic [15:0] base_r,   base_nxt;
  logic [15:0] offs_r,   offs_nxt;
  logic [1:0]  phase_r,  phase_nxt;
  logic [7:0]  red_r,    red_nxt;
  logic [7:0]  grn_r,    grn_nxt;
  logic [7:0]  blu_r,    blu_nxt;
  logic        drop_r,   drop_nxt;
  logic [15:0] matrix_r, matrix_nxt;

  // Divider
  logic [15:0] quo_r, quo_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [8:0]  trial;
  logic [8:0]  diff;
  logic        ge;
  logic [7:0]  snum_m1;
  logic [23:0] prod;

  // Result register
  logic        ov_r, ov_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  ored_r, ored_nxt;
  logic [7:0]  ogrn_r, ogrn_nxt;
  logic [7:0]  oblu_r, oblu_nxt;
  logic [7:0]  ack_r, ack_nxt;
  logic [2:0]  err_r, err_nxt;

  // Per-byte scratch
  logic        res;
  logic [16:0] p;
  logic [16:0] pix_sum;
  logic        need_div;

  assign matrix_pixels  = matrix_r;
  assign stat.need_div  = need_div;
  assign stat.out_stall = ov_r && !out_ready;

  assign out_valid = ov_r;
  assign out_kind  = kind_r;
  assign out_index = idx_r;
  assign out_red   = ored_r;
  assign out_green = ogrn_r;
  assign out_blue  = oblu_r;
  assign out_ack   = ack_r;
  assign out_err   = err_r;

  // Restoring division step and slice scaling
  assign trial   = {rem_r, quo_r[15]};
  assign diff    = trial - {1'b0, stot_r};
  assign ge      = (trial >= {1'b0, stot_r});
  assign snum_m1 = snum_r - 8'd1;
  assign prod    = 24'(quo_r) * 24'(snum_m1);

  assign p       = pos_r - lfr_pkg::POS_PAYLOAD;
  assign pix_sum = {1'b0, base_r} + {1'b0, offs_r};

  always_comb begin
    pos_nxt    = pos_r;
    ftype_nxt  = ftype_r;
    flen_nxt   = flen_r;
    limit_nxt  = limit_r;
    snum_nxt   = snum_r;
    stot_nxt   = stot_r;
    base_nxt   = base_r;
    offs_nxt   = offs_r;
    phase_nxt  = phase_r;
    red_nxt    = red_r;
    grn_nxt    = grn_r;
    blu_nxt    = blu_r;
    drop_nxt   = drop_r;
    matrix_nxt = cfg_we ? cfg_wdata : matrix_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    need_div   = 1'b0;

    res      = 1'b0;
    kind_nxt = lfr_pkg::KIND_PIXEL;
    idx_nxt  = '0;
    ored_nxt = '0;
    ogrn_nxt = '0;
    oblu_nxt = '0;
    ack_nxt  = '0;
    err_nxt  = lfr_pkg::ERR_NONE;

    if (cmd.div_step) begin
      rem_nxt = ge ? diff[7:0] : trial[7:0];
      quo_nxt = {quo_r[14:0], ge};
    end
    if (cmd.mul_load) begin
      base_nxt = (|prod[23:16]) ? 16'hFFFF : prod[15:0];
    end

    if (cmd.accept) begin
      if (!drop_r) begin
        if (pos_r == lfr_pkg::POS_START) begin
          if (in_data != lfr_pkg::START_BYTE) begin
            res      = 1'b1;
            kind_nxt = lfr_pkg::KIND_DROP;
            err_nxt  = lfr_pkg::ERR_BAD_START;
            drop_nxt = 1'b1;
          end
        end else if (pos_r == lfr_pkg::POS_TYPE) begin
          ftype_nxt = in_data;
        end else if (pos_r == lfr_pkg::POS_LEN_HI) begin
          flen_nxt = {in_data, 8'd0};
        end else if (pos_r == lfr_pkg::POS_LEN_LO) begin
          flen_nxt = {flen_r[15:8], in_data};
        end else if (pos_r == lfr_pkg::POS_INDEX) begin
          snum_nxt  = in_data;
          // whole RGB triples end here
          limit_nxt = flen_r - 16'(lfr_pkg::mod3_16(flen_r));
        end else if (pos_r == lfr_pkg::POS_COUNT) begin
          stot_nxt  = in_data;
          offs_nxt  = '0;
          phase_nxt = '0;
          if (ftype_r == lfr_pkg::TYPE_DATA) begin
            if (snum_r == 8'd0 || in_data == 8'd0) begin
              res      = 1'b1;
              kind_nxt = lfr_pkg::KIND_DROP;
              err_nxt  = lfr_pkg::ERR_BAD_SLICE;
              drop_nxt = 1'b1;
            end else begin
              need_div = !in_last;
              quo_nxt  = matrix_r;
              rem_nxt  = '0;
            end
          end
        end else begin
          if (ftype_r == lfr_pkg::TYPE_CMD) begin
            if (p == 17'd1) begin
              red_nxt = in_data;
            end else if (p == 17'd2) begin
              grn_nxt = in_data;
            end else if (p == 17'd3) begin
              blu_nxt = in_data;
            end
          end else if (ftype_r == lfr_pkg::TYPE_DATA && p < {1'b0, limit_r}) begin
            if (phase_r == 2'd0) begin
              red_nxt   = in_data;
              phase_nxt = 2'd1;
            end else if (phase_r == 2'd1) begin
              grn_nxt   = in_data;
              phase_nxt = 2'd2;
            end else begin
              if (pix_sum < {1'b0, matrix_r}) begin
                res      = 1'b1;
                kind_nxt = lfr_pkg::KIND_PIXEL;
                idx_nxt  = pix_sum[15:0];
                ored_nxt = red_r;
                ogrn_nxt = grn_r;
                oblu_nxt = in_data;
              end
              offs_nxt  = offs_r + 16'd1;
              phase_nxt = 2'd0;
            end
          end
          if (p == {1'b0, flen_r}) begin
            if (in_data != lfr_pkg::END_BYTE) begin
              res      = 1'b1;
              kind_nxt = lfr_pkg::KIND_DROP;
              idx_nxt  = '0;
              ored_nxt = '0;
              ogrn_nxt = '0;
              oblu_nxt = '0;
              err_nxt  = lfr_pkg::ERR_BAD_END;
              drop_nxt = 1'b1;
            end else if (ftype_r == lfr_pkg::TYPE_DATA) begin
              res      = 1'b1;
              kind_nxt = lfr_pkg::KIND_COMMIT;
              idx_nxt  = '0;
              ored_nxt = '0;
              ogrn_nxt = '0;
              oblu_nxt = '0;
              drop_nxt = 1'b1;
            end else if (ftype_r == lfr_pkg::TYPE_RESP) begin
              res      = 1'b1;
              kind_nxt = lfr_pkg::KIND_ACK;
              ack_nxt  = lfr_pkg::ACK_BYTE;
              drop_nxt = 1'b1;
            end else if (ftype_r != lfr_pkg::TYPE_CMD) begin
              res      = 1'b1;
              kind_nxt = lfr_pkg::KIND_DROP;
              err_nxt  = lfr_pkg::ERR_BAD_TYPE;
              drop_nxt = 1'b1;
            end
          end
          // clear colour once both the end byte and the blue byte are in
          if (!drop_nxt && ftype_r == lfr_pkg::TYPE_CMD && p >= {1'b0, flen_r} &&
              p >= 17'd3) begin
            res      = 1'b1;
            kind_nxt = lfr_pkg::KIND_CLEAR;
            ored_nxt = red_nxt;
            ogrn_nxt = grn_nxt;
            oblu_nxt = blu_nxt;
            drop_nxt = 1'b1;
          end
        end
        if (!drop_nxt) begin
          pos_nxt = pos_r + 17'd1;
        end
      end

      if (in_last) begin
        // short packet replaces whatever this byte produced
        if (!drop_nxt) begin
          res      = 1'b1;
          kind_nxt = lfr_pkg::KIND_DROP;
          idx_nxt  = '0;
          ored_nxt = '0;
          ogrn_nxt = '0;
          oblu_nxt = '0;
          ack_nxt  = '0;
          err_nxt  = lfr_pkg::ERR_SHORT;
        end
        need_div  = 1'b0;
        pos_nxt   = '0;
        ftype_nxt = '0;
        flen_nxt  = '0;
        limit_nxt = '0;
        snum_nxt  = '0;
        stot_nxt  = '0;
        base_nxt  = '0;
        offs_nxt  = '0;
        phase_nxt = '0;
        red_nxt   = '0;
        grn_nxt   = '0;
        blu_nxt   = '0;
        drop_nxt  = 1'b0;
      end
    end

    ov_nxt = res ? 1'b1 : (ov_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ftype_r  <= '0;
      flen_r   <= '0;
      limit_r  <= '0;
      snum_r   <= '0;
      stot_r   <= '0;
      base_r   <= '0;
      offs_r   <= '0;
      phase_r  <= '0;
      red_r    <= '0;
      grn_r    <= '0;
      blu_r    <= '0;
      drop_r   <= 1'b0;
      matrix_r <= lfr_pkg::MATRIX_RESET;
      ov_r     <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      ftype_r  <= ftype_nxt;
      flen_r   <= flen_nxt;
      limit_r  <= limit_nxt;
      snum_r   <= snum_nxt;
      stot_r   <= stot_nxt;
      base_r   <= base_nxt;
      offs_r   <= offs_nxt;
      phase_r  <= phase_nxt;
      red_r    <= red_nxt;
      grn_r    <= grn_nxt;
      blu_r    <= blu_nxt;
      drop_r   <= drop_nxt;
      matrix_r <= matrix_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Divider and result payload: no reset needed
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (res) begin
      kind_r <= kind_nxt;
      idx_r  <= idx_nxt;
      ored_r <= ored_nxt;
      ogrn_r <= ogrn_nxt;
      oblu_r <= oblu_nxt;
      ack_r  <= ack_nxt;
      err_r  <= err_nxt;
    end
  end

  a_pix_in_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && kind_r == lfr_pkg::KIND_PIXEL) |-> (idx_r < matrix_r))
    else $error("pixel result lies outside the matrix");

  a_err_only_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ((kind_r == lfr_pkg::KIND_DROP) == (err_r != lfr_pkg::ERR_NONE)))
    else $error("error code and drop kind disagree");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |-> !res)
    else $error("new result would overwrite an untaken one");

endmodule

[design/led_frame_packet_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_packet_receiver
// Byte-wise LED frame packet parser with APB-style configuration.
// ----------------------------------------------------------------------------
// A result beat is registered and appears in the cycle after the byte beat that
// causes it. One byte per cycle while input is not stalled; after the
//   packet-count byte of a good data frame, input stalls for 16 restoring-divider
//   steps (matrix_pixels / count) and a step to scale by index - 1 and saturate.
// A pending result that is not taken holds off the next byte beat.
// Reset (rst_n low, synchronous): packet state clears, matrix_pixels = 256.
// ----------------------------------------------------------------------------
module led_frame_packet_receiver (
  input  logic                         clk,
  input  logic                         rst_n,
  lfr_in_if.sink                       in_bus,
  lfr_out_if.source                    out_bus,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfr_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  lfr_pkg::lfr_cmd_t  cmd;
  lfr_pkg::lfr_stat_t stat;
  logic               cfg_we;
  logic [15:0]        matrix_pixels;

  // Configuration: single register, zero wait states. Write on the access
  // phase; ignore any address other than the matrix size register.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == lfr_pkg::ADDR_MATRIX);
  assign prdata = (paddr == lfr_pkg::ADDR_MATRIX) ? {16'd0, matrix_pixels} : 32'd0;

  // Sequencer: gates byte beats while the result register is blocked or the
  // slice-base divider is running.
  lfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: header capture, pixel placement, frame end checks and the
  // registered result beat.
  lfr_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_data       (in_bus.data_byte),
    .in_last       (in_bus.last_byte),
    .cfg_we        (cfg_we),
    .cfg_wdata     (pwdata[15:0]),
    .matrix_pixels (matrix_pixels),
    .out_ready     (out_bus.ready),
    .out_valid     (out_bus.valid),
    .out_kind      (out_bus.result_kind),
    .out_index     (out_bus.pixel_index),
    .out_red       (out_bus.red),
    .out_green     (out_bus.green),
    .out_blue      (out_bus.blue),
    .out_ack       (out_bus.ack_byte),
    .out_err       (out_bus.error_code)
  );

endmodule
